[design/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(name, clk, rstn, pre, post)
`define ASSERT_NEXT(name, clk, rstn, pre, post)
`endif

`endif

[design/tcrc_pkg.sv]
package tcrc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd5;

    localparam logic [1:0] ROT_NORMAL = 2'd0;
    localparam logic [1:0] ROT_LEFT   = 2'd1;
    localparam logic [1:0] ROT_INVERT = 2'd2;
    localparam logic [1:0] ROT_RIGHT  = 2'd3;

    localparam logic [FIELD_W-1:0] RST_MIN_X = 16'd130;
    localparam logic [FIELD_W-1:0] RST_MIN_Y = 16'd250;
    localparam logic [FIELD_W-1:0] RST_MAX_X = 16'd3820;
    localparam logic [FIELD_W-1:0] RST_MAX_Y = 16'd3920;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_PREP  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
    localparam logic [OP_W-1:0] OP_FINAL = 3'd4;
    localparam logic [OP_W-1:0] OP_CAL   = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NONE     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_IN    = 3'd2;
    localparam logic [COND_W-1:0] C_DROP     = 3'd3;
    localparam logic [COND_W-1:0] C_CAL      = 3'd4;
    localparam logic [COND_W-1:0] C_NOROT    = 3'd5;
    localparam logic [COND_W-1:0] C_CNT      = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_FULL = 3'd7;

    // program steps
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [UPC_W-1:0] STEP_PREP  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_MUL   = 3'd3;
    localparam logic [UPC_W-1:0] STEP_DIV   = 3'd4;
    localparam logic [UPC_W-1:0] STEP_FINAL = 3'd5;
    localparam logic [UPC_W-1:0] STEP_CAL   = 3'd6;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idle;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic ok;
        logic cal;
        logic norot;
        logic out_full;
    } t_status;

    typedef struct packed {
        logic               report_ok;
        logic               contact;
        logic [FIELD_W-1:0] raw_x;
        logic [FIELD_W-1:0] raw_y;
    } t_in_beat;

    typedef struct packed {
        logic               is_position;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic               contact_out;
        logic [FIELD_W-1:0] seen_min_x;
        logic [FIELD_W-1:0] seen_min_y;
        logic [FIELD_W-1:0] seen_max_x;
        logic [FIELD_W-1:0] seen_max_y;
    } t_out_beat;

    // control store; a step that does not jump falls through, the last wraps to idle
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:  w = '{op: OP_NOP,   cond: C_NO_IN,    target: STEP_IDLE};
            STEP_CHECK: w = '{op: OP_NOP,   cond: C_DROP,     target: STEP_IDLE};
            STEP_PREP:  w = '{op: OP_PREP,  cond: C_CAL,      target: STEP_CAL};
            STEP_MUL:   w = '{op: OP_MUL,   cond: C_NOROT,    target: STEP_FINAL};
            STEP_DIV:   w = '{op: OP_DIV,   cond: C_CNT,      target: STEP_DIV};
            STEP_FINAL: w = '{op: OP_FINAL, cond: C_ALWAYS,   target: STEP_EMIT};
            STEP_CAL:   w = '{op: OP_CAL,   cond: C_NONE,     target: STEP_IDLE};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FULL, target: STEP_EMIT};
        endcase
        return w;
    endfunction

endpackage

[design/touch_coordinate_rotate_calibrate_unit.sv]
// Touch report mapper with orientation handling and a calibration tracker.
// Input channel: one beat per touch report (i_in_valid / o_in_stall, payload
// i_in_data). Output channel: one beat per result (o_out_valid / i_out_stall).
// A report with report_ok clear is consumed and yields no beat.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index; write
// only while the block is idle.
// A small microprogram steps one report at a time through a shared datapath.
// Steps after acceptance: check, prep, then cal when calibrating; mul and final
// for the normal and inverted orientations; mul, divide loop and final for left
// and right, where both scale terms run through a restoring divider, one bit a
// cycle; then emit. A dropped report returns to idle from check. The next report
// is taken in the cycle after the result is loaded.
// A finished result sits in the output register; if it is still stalled when
// the next result is ready, the sequencer waits at its emit step.
// Reset (synchronous, i_rst_n low) returns the sequencer to idle, empties the
// output register, loads the register defaults and clears the tracked extremes.
`include "assert_macros.svh"

module touch_coordinate_rotate_calibrate_unit #(
    parameter int COORD_BITS = tcrc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tcrc_pkg::t_in_beat                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tcrc_pkg::t_out_beat               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [tcrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tcrc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int RW = 2 * COORD_BITS + 2;

    // configuration
    logic [1:0]    r_rot;
    logic          r_cal;
    logic [CB-1:0] r_span_min_x, r_span_min_y, r_span_max_x, r_span_max_y;

    // captured report
    logic          r_ok, r_contact;
    logic [CB-1:0] r_x, r_y;

    // tracked extremes
    logic [CB-1:0] r_trk_min_x, r_trk_min_y, r_trk_max_x, r_trk_max_y;

    // pending result
    logic          r_is_pos;
    logic [CB-1:0] r_pos_x, r_pos_y;

    logic          r_out_valid;
    t_out_beat     r_out;

    t_ctrl   w_ctrl;
    t_status w_status;
    logic    w_in_acc, w_out_load;
    logic    w_cal_beat, w_pos_zero;

    logic signed [CB:0]   w_dx, w_dy, w_sx, w_sy;
    logic signed [2*CB:0] w_t0, w_t1;
    logic signed [RW-1:0] e_x, e_y, e_min_x, e_min_y, e_max_x, e_max_y, e_t0, e_t1;
    logic signed [RW-1:0] w_rx, w_ry;
    logic [CB-1:0]        w_sat_x, w_sat_y;

    assign w_in_acc   = i_in_valid && w_ctrl.idle;
    assign o_in_stall = !w_ctrl.idle;

    always_comb begin
        w_status.in_valid = i_in_valid;
        w_status.ok       = r_ok;
        w_status.cal      = r_cal;
        w_status.norot    = (r_rot == ROT_NORMAL) || (r_rot == ROT_INVERT);
        w_status.out_full = r_out_valid && i_out_stall;
    end

    assign w_out_load = (w_ctrl.op == OP_EMIT) && !w_status.out_full;

    tcrc_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    assign w_dx = {1'b0, r_x} - {1'b0, r_span_min_x};
    assign w_dy = {1'b0, r_y} - {1'b0, r_span_min_y};
    assign w_sx = {1'b0, r_span_max_x} - {1'b0, r_span_min_x};
    assign w_sy = {1'b0, r_span_max_y} - {1'b0, r_span_min_y};

    // x lane: dy * sx / sy, y lane: dx * sy / sx
    tcrc_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_op   (w_ctrl.op),
        .i_d    (w_dy),
        .i_num  (w_sx),
        .i_den  (w_sy),
        .o_term (w_t0)
    );

    tcrc_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_op   (w_ctrl.op),
        .i_d    (w_dx),
        .i_num  (w_sy),
        .i_den  (w_sx),
        .o_term (w_t1)
    );

    always_comb begin
        e_x     = RW'(r_x);
        e_y     = RW'(r_y);
        e_min_x = RW'(r_span_min_x);
        e_min_y = RW'(r_span_min_y);
        e_max_x = RW'(r_span_max_x);
        e_max_y = RW'(r_span_max_y);
        e_t0    = RW'(w_t0);
        e_t1    = RW'(w_t1);
        unique case (r_rot)
            ROT_LEFT: begin
                w_rx = e_max_x - e_t0;
                w_ry = e_min_y + e_t1;
            end
            ROT_INVERT: begin
                w_rx = e_max_x + e_min_x - e_x;
                w_ry = e_max_y + e_min_y - e_y;
            end
            ROT_RIGHT: begin
                w_rx = e_min_x + e_t0;
                w_ry = e_max_y - e_t1;
            end
            default: begin
                w_rx = e_x;
                w_ry = e_y;
            end
        endcase
        w_sat_x = w_rx[RW-1] ? '0 : ((|w_rx[RW-2:CB]) ? '1 : w_rx[CB-1:0]);
        w_sat_y = w_ry[RW-1] ? '0 : ((|w_ry[RW-2:CB]) ? '1 : w_ry[CB-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot        <= ROT_NORMAL;
            r_cal        <= 1'b0;
            r_span_min_x <= RST_MIN_X[CB-1:0];
            r_span_min_y <= RST_MIN_Y[CB-1:0];
            r_span_max_x <= RST_MAX_X[CB-1:0];
            r_span_max_y <= RST_MAX_Y[CB-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROT:   r_rot        <= i_cfg_data[1:0];
                REG_CAL:   r_cal        <= i_cfg_data[0];
                REG_MIN_X: r_span_min_x <= i_cfg_data[CB-1:0];
                REG_MIN_Y: r_span_min_y <= i_cfg_data[CB-1:0];
                REG_MAX_X: r_span_max_x <= i_cfg_data[CB-1:0];
                REG_MAX_Y: r_span_max_y <= i_cfg_data[CB-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ok      <= i_in_data.report_ok;
            r_contact <= i_in_data.contact;
            r_x       <= i_in_data.raw_x[CB-1:0];
            r_y       <= i_in_data.raw_y[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk_min_x <= '0;
            r_trk_min_y <= '0;
            r_trk_max_x <= '0;
            r_trk_max_y <= '0;
        end else if (w_ctrl.op == OP_CAL) begin
            // a zero minimum is unset
            if ((r_trk_min_x == '0) || (r_x < r_trk_min_x)) begin
                r_trk_min_x <= r_x;
            end
            if ((r_trk_min_y == '0) || (r_y < r_trk_min_y)) begin
                r_trk_min_y <= r_y;
            end
            if (r_x > r_trk_max_x) begin
                r_trk_max_x <= r_x;
            end
            if (r_y > r_trk_max_y) begin
                r_trk_max_y <= r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_FINAL) begin
            r_is_pos <= 1'b1;
            r_pos_x  <= w_sat_x;
            r_pos_y  <= w_sat_y;
        end else if (w_ctrl.op == OP_CAL) begin
            r_is_pos <= 1'b0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.is_position <= r_is_pos;
            r_out.pos_x       <= FIELD_W'(r_pos_x);
            r_out.pos_y       <= FIELD_W'(r_pos_y);
            r_out.contact_out <= r_contact;
            r_out.seen_min_x  <= FIELD_W'(r_trk_min_x);
            r_out.seen_min_y  <= FIELD_W'(r_trk_min_y);
            r_out.seen_max_x  <= FIELD_W'(r_trk_max_x);
            r_out.seen_max_y  <= FIELD_W'(r_trk_max_y);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_cal_beat = o_out_valid && !o_out_data.is_position;
    assign w_pos_zero = (o_out_data.pos_x == '0) && (o_out_data.pos_y == '0);

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_in_stall)
    `ASSERT_IMPL(a_cal_beat_no_pos, i_clk, i_rst_n, w_cal_beat, w_pos_zero)
    `ASSERT_IMPL(a_min_le_max_x, i_clk, i_rst_n, r_trk_min_x != '0, r_trk_min_x <= r_trk_max_x)
    `ASSERT_IMPL(a_min_le_max_y, i_clk, i_rst_n, r_trk_min_y != '0, r_trk_min_y <= r_trk_max_y)

endmodule

[design/tcrc_seq.sv]
module tcrc_seq #(
    parameter int COORD_BITS = tcrc_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcrc_pkg::t_status i_status,
    output tcrc_pkg::t_ctrl   o_ctrl
);
    import tcrc_pkg::*;

    localparam int CNT_W = $clog2(2 * COORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(2 * COORD_BITS - 1);

    logic [UPC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           w_uw;
    logic             w_take;

    always_comb begin
        w_uw = ucode(r_pc);
        unique case (w_uw.cond)
            C_NONE:     w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = !i_status.in_valid;
            C_DROP:     w_take = !i_status.ok;
            C_CAL:      w_take = i_status.cal;
            C_NOROT:    w_take = i_status.norot;
            C_CNT:      w_take = (r_cnt != '0);
            C_OUT_FULL: w_take = i_status.out_full;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + UPC_W'(1);

        n_cnt = r_cnt;
        if (w_uw.op == OP_MUL) begin
            n_cnt = CNT_LOAD;
        end else if (w_uw.op == OP_DIV) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= STEP_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    assign o_ctrl.op   = w_uw.op;
    assign o_ctrl.idle = (r_pc == STEP_IDLE);

endmodule

[design/tcrc_lane.sv]
module tcrc_lane #(
    parameter int COORD_BITS = tcrc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [tcrc_pkg::OP_W-1:0]     i_op,
    input  logic signed [COORD_BITS:0]    i_d,
    input  logic signed [COORD_BITS:0]    i_num,
    input  logic signed [COORD_BITS:0]    i_den,
    output logic signed [2*COORD_BITS:0]  o_term
);
    import tcrc_pkg::*;

    localparam int PW = 2 * COORD_BITS;

    logic                  r_neg, r_zero;
    logic [COORD_BITS-1:0] r_mag_d, r_mag_n, r_mag_den, r_rem;
    logic [PW-1:0]         r_quo;

    logic [COORD_BITS:0]   w_d_neg, w_n_neg, w_den_neg;
    logic [COORD_BITS-1:0] w_abs_d, w_abs_n, w_abs_den;
    logic [PW-1:0]         w_prod;
    logic [COORD_BITS:0]   w_trial, w_diff;
    logic                  w_ge;
    logic [PW:0]           w_q;

    always_comb begin
        w_d_neg   = -i_d;
        w_n_neg   = -i_num;
        w_den_neg = -i_den;
        w_abs_d   = i_d[COORD_BITS]   ? w_d_neg[COORD_BITS-1:0]   : i_d[COORD_BITS-1:0];
        w_abs_n   = i_num[COORD_BITS] ? w_n_neg[COORD_BITS-1:0]   : i_num[COORD_BITS-1:0];
        w_abs_den = i_den[COORD_BITS] ? w_den_neg[COORD_BITS-1:0] : i_den[COORD_BITS-1:0];

        w_prod  = {{COORD_BITS{1'b0}}, r_mag_d} * {{COORD_BITS{1'b0}}, r_mag_n};

        // restoring divide, one quotient bit a step
        w_trial = {r_rem, r_quo[PW-1]};
        w_diff  = w_trial - {1'b0, r_mag_den};
        w_ge    = (w_trial >= {1'b0, r_mag_den});

        w_q    = {1'b0, r_quo};
        o_term = r_zero ? '0 : (r_neg ? -w_q : w_q);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_PREP: begin
                r_neg     <= i_d[COORD_BITS] ^ i_num[COORD_BITS] ^ i_den[COORD_BITS];
                r_zero    <= (i_den == '0);
                r_mag_d   <= w_abs_d;
                r_mag_n   <= w_abs_n;
                r_mag_den <= w_abs_den;
            end
            OP_MUL: begin
                r_quo <= w_prod;
                r_rem <= '0;
            end
            OP_DIV: begin
                r_quo <= {r_quo[PW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule
